### sv/totp_pkg.sv
// Package with SHA-256 constants, widths and helper functions for the TOTP block.
`timescale 1ns / 1ps
package totp_pkg;

  localparam int unsigned KeyWords = 8;

  typedef logic [31:0] word_t;

  localparam word_t IvConst [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RkConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_s0(input word_t x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_s1(input word_t x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/totp_if.sv
// Valid/ready channel interfaces for the TOTP block.
`timescale 1ns / 1ps
interface totp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_time;
  modport source (output valid, output unix_time, input ready);
  modport sink (input valid, input unix_time, output ready);
endinterface

interface totp_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] otp_code;
  logic [4:0]  seconds_left;
  modport source (output valid, output otp_code, output seconds_left, input ready);
  modport sink (input valid, input otp_code, input seconds_left, output ready);
endinterface

interface totp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/totp_hmac_sha256_code.sv
// Top level: TOTP code generator over HMAC-SHA256 with RFC 4226 truncation.
// Steps from the accepting edge to out valid: the time step division, four SHA-256
// compressions (load, 64 rounds, add, block switch), truncation, the modulo and the
// load of the output register.
// A new time is taken only once the last result is in the output register; that
// result waits there while the next transaction is taken. Reset (rst_n, synchronous, active low)
// clears the key registers and control.
`timescale 1ns / 1ps
module totp_hmac_sha256_code
  import totp_pkg::*;
#(
  parameter int unsigned WINDOW_SECS = 30,
  parameter int unsigned OTP_DIGITS  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  totp_in_if.sink           in_ch,
  totp_out_if.source        out_ch,
  totp_cfg_if.sink          cfg_ch
);

  // Effective window and modulus, fixed at elaboration.
  localparam longint unsigned WinEff = (WINDOW_SECS < 1) ? 1 : WINDOW_SECS;
  localparam longint unsigned Modulus =
    (OTP_DIGITS >= 10) ? 64'd10000000000 :
    (OTP_DIGITS == 0) ? 64'd1 :
    (64'd10 ** OTP_DIGITS);

  // Divisors and their reciprocals floor(2^32 / d). A divisor of one needs the full
  // 33 bits. The truncated sample is below 2^31, so with ten or more digits a divisor
  // of 2^32 passes it through unchanged, just as the larger modulus would.
  localparam logic [32:0] WinDiv = 33'(WinEff);
  localparam logic [32:0] WinRcp = 33'(64'h1_0000_0000 / WinEff);
  localparam logic [32:0] ModDiv = (OTP_DIGITS >= 10) ? 33'h1_0000_0000 : 33'(Modulus);
  localparam logic [32:0] ModRcp = 33'(64'h1_0000_0000 / 64'(ModDiv));

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_ADD, ST_NEXT,
    ST_TRUNC, ST_MOD, ST_OUT
  } state_t;

  state_t      state_r;
  logic [63:0] key_r [KeyWords];

  // Division by a constant: the reciprocal gives a quotient that is at most one
  // short, and a single compare and subtract finishes it.
  logic [31:0] dvd_r;
  logic [31:0] quot_r;
  logic [32:0] prod_r;
  logic [32:0] rem_r;
  logic [1:0]  cnt_r;

  // Hash state.
  word_t       h_r [8];
  word_t       a_r [8];
  word_t       w_r [16];
  logic [6:0]  rnd_r;
  logic [1:0]  blk_r;     // 0: inner key, 1: inner msg, 2: outer key, 3: outer msg
  word_t       inner_r [8];
  logic [4:0]  secs_r;
  logic [4:0]  left_r;
  logic        out_valid_r;
  logic [19:0] code_r;
  logic        out_load;

  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.otp_code = code_r;
  assign out_ch.seconds_left = left_r;

  // The output register takes a new result once the previous one has been taken.
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // Message word j of the current block.
  function automatic word_t blk_word(input logic [1:0] b, input int unsigned j,
                                     input logic [63:0] k [KeyWords],
                                     input logic [31:0] step, input word_t inr [8]);
    word_t v;
    v = '0;
    if (!b[0]) begin
      v = (j[0] ? k[j >> 1][31:0] : k[j >> 1][63:32]) ^ (b[1] ? 32'h5c5c5c5c : 32'h36363636);
    end else if (!b[1]) begin
      // 8-byte counter, padding, length 72 bytes = 576 bits.
      if (j == 1) v = step;
      else if (j == 2) v = 32'h80000000;
      else if (j == 15) v = 32'd576;
    end else begin
      // 32-byte inner hash, padding, length 96 bytes = 768 bits.
      if (j < 8) v = inr[j];
      else if (j == 8) v = 32'h80000000;
      else if (j == 15) v = 32'd768;
    end
    blk_word = v;
  endfunction

  // One round on the shared unit.
  word_t t1, t2, wn, wcur;
  always_comb begin
    wcur = w_r[0];
    t1 = a_r[7] + big_s1(a_r[4]) + ((a_r[4] & a_r[5]) ^ (~a_r[4] & a_r[6]))
         + RkConst[rnd_r[5:0]] + wcur;
    t2 = big_s0(a_r[0]) + ((a_r[0] & a_r[1]) ^ (a_r[0] & a_r[2]) ^ (a_r[1] & a_r[2]));
    wn = w_r[0] + sml_s0(w_r[1]) + w_r[9] + sml_s1(w_r[14]);
  end

  // Shared multiplier for both divisions: the reciprocal product in the first step,
  // the quotient times the divisor in the second.
  logic [32:0] div_sel, rcp_sel, mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  always_comb begin
    div_sel = (state_r == ST_MOD) ? ModDiv : WinDiv;
    rcp_sel = (state_r == ST_MOD) ? ModRcp : WinRcp;
    mul_a   = (cnt_r == 2'd0) ? rcp_sel : div_sel;
    mul_b   = (cnt_r == 2'd0) ? dvd_r : quot_r;
    mul_p   = mul_a * mul_b;
  end

  // Truncation byte pick from the final MAC.
  logic [255:0] mac_flat;
  logic [3:0]   off;
  always_comb begin
    for (int i = 0; i < 8; i++) mac_flat[255 - 32*i -: 32] = h_r[i];
    off = h_r[7][3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KeyWords; i++) key_r[i] <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) key_r[cfg_ch.index] <= cfg_ch.data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            dvd_r   <= in_ch.unix_time;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV, ST_MOD: begin
          cnt_r <= cnt_r + 2'd1;
          case (cnt_r)
            2'd0: quot_r <= mul_p[63:32];
            2'd1: prod_r <= mul_p[32:0];
            2'd2: rem_r  <= {1'b0, dvd_r} - prod_r;
            default: begin
              if (rem_r >= div_sel) begin
                quot_r <= quot_r + 32'd1;
                rem_r  <= rem_r - div_sel;
              end
              if (state_r == ST_DIV) begin
                blk_r   <= 2'd0;
                for (int i = 0; i < 8; i++) h_r[i] <= IvConst[i];
                state_r <= ST_LOAD;
              end else begin
                state_r <= ST_OUT;
              end
            end
          endcase
        end
        ST_LOAD: begin
          secs_r <= 5'(WinEff - rem_r);
          for (int j = 0; j < 16; j++) w_r[j] <= blk_word(blk_r, j, key_r, quot_r, inner_r);
          for (int i = 0; i < 8; i++) a_r[i] <= h_r[i];
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          a_r[0] <= t1 + t2; a_r[1] <= a_r[0]; a_r[2] <= a_r[1]; a_r[3] <= a_r[2];
          a_r[4] <= a_r[3] + t1; a_r[5] <= a_r[4]; a_r[6] <= a_r[5]; a_r[7] <= a_r[6];
          for (int j = 0; j < 15; j++) w_r[j] <= w_r[j + 1];
          w_r[15] <= wn;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + a_r[i];
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          blk_r <= blk_r + 2'd1;
          if (blk_r == 2'd1) begin
            for (int i = 0; i < 8; i++) begin
              inner_r[i] <= h_r[i];
              h_r[i]     <= IvConst[i];
            end
            state_r <= ST_LOAD;
          end else if (blk_r == 2'd3) begin
            state_r <= ST_TRUNC;
          end else begin
            state_r <= ST_LOAD;
          end
        end
        ST_TRUNC: begin
          dvd_r   <= {1'b0, mac_flat[254 - 8*off -: 31]};
          cnt_r   <= '0;
          state_r <= ST_MOD;
        end
        ST_OUT: begin
          if (out_load) begin
            code_r  <= rem_r[19:0];
            left_r  <= secs_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/tb_totp_hmac_sha256_code.sv
// Self-checking testbench for the TOTP block: its own HMAC-SHA256 code predictor.
`timescale 1ns / 1ps
module tb_totp_hmac_sha256_code
  import totp_pkg::*;
();

  localparam int unsigned Window = 30;
  localparam int unsigned Digits = 6;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Latency = 400;

  // A register index that names one of the eight key words.
  typedef enum logic [2:0] {
    KEY_W0, KEY_W1, KEY_W2, KEY_W3, KEY_W4, KEY_W5, KEY_W6, KEY_W7
  } key_reg_e;

  typedef struct packed {
    logic [19:0] code;
    logic [4:0]  left;
  } totp_result_t;

  // One row of the directed table: a time and, where known at a glance, the
  // expected seconds left (the code itself always comes from the predictor).
  typedef struct {
    logic [31:0] utime;
    bit          has_left;
    logic [4:0]  left;
  } time_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  totp_in_if  in_ch ();
  totp_out_if out_ch ();
  totp_cfg_if cfg_ch ();

  totp_hmac_sha256_code #(.WINDOW_SECS(Window), .OTP_DIGITS(Digits)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // The testbench's own copy of the key registers.
  logic [63:0] key_shadow [8];

  totp_result_t expected_codes [$];
  int unsigned mismatch_count = 0;
  int unsigned table_err_count = 0;
  int unsigned checked_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit stim_done = 1'b0;

  // SHA-256 round-level arithmetic, written out here rather than borrowed.
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression of a 512-bit block (first byte at the top) into a state.
  function automatic void sha_compress(inout logic [31:0] st [8],
                                       input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {st[0], st[1], st[2], st[3], st[4], st[5], st[6], st[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RkConst[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    st[0] += a; st[1] += b; st[2] += c; st[3] += d;
    st[4] += e; st[5] += f; st[6] += g; st[7] += h;
  endfunction

  // Hash of one padded-key block followed by a short, already padded tail block.
  function automatic logic [255:0] hash_two(input logic [511:0] first,
                                            input logic [511:0] tail);
    logic [31:0] st [8];
    for (int i = 0; i < 8; i++) st[i] = IvConst[i];
    sha_compress(st, first);
    sha_compress(st, tail);
    return {st[0], st[1], st[2], st[3], st[4], st[5], st[6], st[7]};
  endfunction

  // Full TOTP prediction for one time value under the shadow key.
  function automatic totp_result_t predict_code(input logic [31:0] utime);
    logic [511:0] key_blk, tail;
    logic [255:0] inner, mac;
    logic [63:0]  step;
    logic [31:0]  sample;
    logic [63:0]  modulus;
    int unsigned  off;
    totp_result_t r;
    for (int i = 0; i < 8; i++) key_blk[511 - 64 * i -: 64] = key_shadow[i];
    step = 64'(utime / Window);
    // Inner hash: 64 + 8 bytes = 576 bits of message.
    tail = '0;
    tail[511 -: 64] = step;
    tail[447 -: 8] = 8'h80;
    tail[63:0] = 64'd576;
    inner = hash_two(key_blk ^ {64{8'h36}}, tail);
    // Outer hash: 64 + 32 bytes = 768 bits of message.
    tail = '0;
    tail[511 -: 256] = inner;
    tail[255 -: 8] = 8'h80;
    tail[63:0] = 64'd768;
    mac = hash_two(key_blk ^ {64{8'h5c}}, tail);
    // Dynamic truncation: offset from the low nibble of the last byte.
    off = 32'(mac[3:0]);
    sample = mac[255 - 8 * off -: 32] & 32'h7FFF_FFFF;
    modulus = 1;
    for (int i = 0; i < Digits; i++) modulus *= 10;
    r.code = 20'(64'(sample) % modulus);
    r.left = 5'(Window - utime % Window);
    return r;
  endfunction

  // Key register write through the configuration channel; keeps the shadow copy.
  // Valid stays up so that writes can follow back to back.
  task automatic write_key(input key_reg_e idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    key_shadow[idx] = value;
  endtask

  task automatic load_key(input logic [63:0] words [8]);
    key_reg_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = key_reg_e'(i);
      write_key(idx, words[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Drops the input valid, waits until every expected code has come back, then
  // lets the block settle.
  task automatic drain_codes();
    in_ch.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Offers one time value, idling beforehand at the current sender rate.
  // The expected result is queued when the transaction is accepted; valid stays up
  // so that the next time can follow without a gap.
  task automatic send_time(input logic [31:0] utime);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.unix_time <= utime;
    do @(posedge clk); while (!in_ch.ready);
    expected_codes.push_back(predict_code(utime));
  endtask

  // Times near window borders and near the top of the range, small times and a spread over the whole range.
  function automatic logic [31:0] random_time();
    logic [31:0] t;
    case ($urandom_range(3))
      0: t = $urandom();
      1: t = $urandom_range(100000);
      2: t = 32'(($urandom() / Window) * Window + $urandom_range(1) * (Window - 1));
      default: t = 32'hFFFF_FFFF - $urandom_range(100);
    endcase
    return t;
  endfunction

  // Result side: random back pressure, plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    totp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: code %0d left %0d", out_ch.otp_code,
                   out_ch.seconds_left);
      end else begin
        want = expected_codes.pop_front();
        checked_count++;
        if (want.code !== out_ch.otp_code || want.left !== out_ch.seconds_left) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result %0d: expected code %0d left %0d, got code %0d left %0d",
                     checked_count, want.code, want.left, out_ch.otp_code,
                     out_ch.seconds_left);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // Directed times: window edges, zero and the top of the 32-bit range.
  time_row_t dir_rows [14] = '{
    '{32'd0,          1'b1, 5'd30},
    '{32'd1,          1'b1, 5'd29},
    '{32'd29,         1'b1, 5'd1},
    '{32'd30,         1'b1, 5'd30},
    '{32'd59,         1'b1, 5'd1},
    '{32'd59,         1'b1, 5'd1},
    '{32'd1111111109, 1'b0, 5'd0},
    '{32'd1234567890, 1'b0, 5'd0},
    '{32'd2000000000, 1'b0, 5'd0},
    '{32'h8000_0000,  1'b0, 5'd0},
    '{32'h5555_5555,  1'b0, 5'd0},
    '{32'hAAAA_AAAA,  1'b0, 5'd0},
    '{32'hFFFF_FFFE,  1'b0, 5'd0},
    '{32'hFFFF_FFFF,  1'b1, 5'd15}
  };

  initial begin
    logic [63:0] kw [8];
    totp_result_t p;
    in_ch.valid = 1'b0;
    in_ch.unix_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = KEY_W0;
    cfg_ch.data = '0;
    for (int i = 0; i < 8; i++) key_shadow[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the all-zero key left from reset; table values for the
    // seconds left are cross-checked against the predictor before use.
    send_idle_pct = 18;
    recv_idle_pct = 67;
    foreach (dir_rows[i]) begin
      p = predict_code(dir_rows[i].utime);
      if (dir_rows[i].has_left && p.left !== dir_rows[i].left) begin
        table_err_count++;
        $display("Table row %0d: seconds left %0d, table says %0d", i, p.left,
                 dir_rows[i].left);
      end
      send_time(dir_rows[i].utime);
    end
    drain_codes();

    // The standard 20-byte ASCII test key, zero padded, then all-ones key.
    kw = '{64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000,
           64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
    load_key(kw);
    foreach (dir_rows[i]) send_time(dir_rows[i].utime);
    drain_codes();
    for (int i = 0; i < 8; i++) kw[i] = '1;
    load_key(kw);
    send_time(32'd59);
    send_time(32'hFFFF_FFFF);
    send_time(32'd0);

    // Long receiver hold-off while the sender keeps offering, so the input stalls.
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_time(random_time());
    join
    drain_codes();

    // Random part in three idling phases: fresh random keys in the first two, the zero key in the last.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 18 : 0;
      for (int i = 0; i < 8; i++) kw[i] = {$urandom(), $urandom()};
      if (ph == 2) kw = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
      load_key(kw);
      for (int n = 0; n < 205; n++) send_time(random_time());
      drain_codes();
    end

    stim_done = 1'b1;
    $display("Covered %0d checked codes over reset, test, all-ones and random keys,",
             checked_count);
    $display("with window edges, 32-bit extremes, long back pressure and three idle mixes.");
    if (mismatch_count == 0 && table_err_count == 0 && expected_codes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
sv/totp_pkg.sv
sv/totp_if.sv
sv/totp_hmac_sha256_code.sv
tb/sv/tb_totp_hmac_sha256_code.sv
